// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL file indexed_doubly_linked_list.sv.
// Every check is clocked on clk; the reset-qualified form disables on rst_n low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, held off during reset.
`define CHK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define CHK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/idll_pkg.sv =====
// Shared types, widths, codes and helpers for the indexed doubly linked list.
// No dependencies.
package idll_pkg;

    localparam int NODE_CNT = 1024;
    localparam int ID_W     = 10;
    localparam int LINK_W   = ID_W + 1;
    localparam int ADDR_W   = $clog2(NODE_CNT);
    localparam int IN_W     = 24;
    localparam int OUT_W    = 40;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam link_t LINK_NULL = {1'b1, {ID_W{1'b0}}};

    typedef struct packed {
        logic  en;
        addr_t addr;
        link_t data;
    } wr_req_t;

    function automatic link_t to_link(id_t id);
        return {1'b0, id};
    endfunction

    function automatic addr_t slot(id_t id);
        return addr_t'(id);
    endfunction

    function automatic logic is_null(link_t link);
        return link[ID_W];
    endfunction

    function automatic id_t link_id(link_t link);
        return link[ID_W] ? id_t'(0) : link[ID_W-1:0];
    endfunction

endpackage

// ===== sv/indexed_doubly_linked_list.sv =====
// Indexed doubly linked list: left/right link memories indexed by node id, plus head pointer.
// Flow: idle accepts a word and reads the link memories, exec applies it, an insert beside a
// target adds a second write pass (each memory has one write port, and such an insert writes
// up to two entries in each), and finish loads the output register or holds while it is full.
// s_tready is high only in idle, so no new word is taken before the last one has been loaded.
// Reset: head pointer null, sequencer idle, output valid cleared; link memories not cleared.
`include "assert_macros.svh"

module indexed_doubly_linked_list
    import idll_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,  // node_id, anchor_id, target_none, side, zero pad
    input  logic [1:0]       s_tuser,  // kind
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata   // head_id, head_none, left_id, left_none,
                                       // right_id, right_none, zero pad
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WR2  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [1:0] kind_reg;
    id_t        node_reg;
    id_t        target_reg;
    logic       tnone_reg;
    logic       side_reg;

    link_t mem_l [NODE_CNT];
    link_t mem_r [NODE_CNT];
    link_t rd_l, rd_r;
    addr_t raddr;

    wr_req_t wl_req, wr_req;
    wr_req_t wl2_reg, wl2_next;
    wr_req_t wr2_reg, wr2_next;

    link_t head_reg, head_next;
    link_t left_reg, left_next;
    link_t right_reg, right_next;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_load;
    logic             accept;

    id_t in_node, in_target;

    assign in_node   = s_tdata[ID_W-1:0];
    assign in_target = s_tdata[2*ID_W-1:ID_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign raddr     = slot((s_tuser == KIND_INSERT) ? in_target : in_node);

    // link memories: one read port, one write port each
    always_ff @(posedge clk)
    begin
        rd_l <= mem_l[raddr];
        rd_r <= mem_r[raddr];
        if (wl_req.en)
        begin
            mem_l[wl_req.addr] <= wl_req.data;
        end
        if (wr_req.en)
        begin
            mem_r[wr_req.addr] <= wr_req.data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        wl_req     = '0;
        wr_req     = '0;
        wl2_next   = wl2_reg;
        wr2_next   = wr2_reg;
        head_next  = head_reg;
        left_next  = left_reg;
        right_next = right_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FIN;
                left_next  = rd_l;
                right_next = rd_r;
                unique case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (tnone_reg)
                        begin
                            wl_req     = '{1'b1, slot(node_reg), LINK_NULL};
                            wr_req     = '{1'b1, slot(node_reg), LINK_NULL};
                            head_next  = to_link(node_reg);
                            left_next  = LINK_NULL;
                            right_next = LINK_NULL;
                        end
                        else if (!side_reg)
                        begin
                            // link in left of target; rd_l is the target's left link
                            if (!is_null(rd_l))
                            begin
                                wr_req = '{1'b1, slot(rd_l[ID_W-1:0]), to_link(node_reg)};
                            end
                            else
                            begin
                                head_next = to_link(node_reg);
                            end
                            wl_req     = '{1'b1, slot(node_reg), rd_l};
                            wl2_next   = '{1'b1, slot(target_reg), to_link(node_reg)};
                            wr2_next   = '{1'b1, slot(node_reg), to_link(target_reg)};
                            left_next  = (target_reg == node_reg) ? to_link(node_reg) : rd_l;
                            right_next = to_link(target_reg);
                            state_next = ST_WR2;
                        end
                        else
                        begin
                            // link in right of target; rd_r is the target's right link
                            if (!is_null(rd_r))
                            begin
                                wl_req = '{1'b1, slot(rd_r[ID_W-1:0]), to_link(node_reg)};
                            end
                            wr_req     = '{1'b1, slot(node_reg), rd_r};
                            wl2_next   = '{1'b1, slot(node_reg), to_link(target_reg)};
                            wr2_next   = '{1'b1, slot(target_reg), to_link(node_reg)};
                            left_next  = to_link(target_reg);
                            right_next = (target_reg == node_reg) ? to_link(node_reg) : rd_r;
                            state_next = ST_WR2;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (!is_null(rd_l))
                        begin
                            wr_req = '{1'b1, slot(rd_l[ID_W-1:0]), rd_r};
                        end
                        else
                        begin
                            head_next = rd_r;
                        end
                        if (!is_null(rd_r))
                        begin
                            wl_req = '{1'b1, slot(rd_r[ID_W-1:0]), rd_l};
                        end
                    end
                    KIND_QUERY:
                    begin
                        state_next = ST_FIN;
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_WR2:
            begin
                wl_req     = wl2_reg;
                wr_req     = wr2_reg;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= LINK_NULL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= s_tuser;
            node_reg   <= in_node;
            target_reg <= in_target;
            tnone_reg  <= s_tdata[2*ID_W];
            side_reg   <= s_tdata[2*ID_W+1];
        end
        wl2_reg   <= wl2_next;
        wr2_reg   <= wr2_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        if (out_load)
        begin
            out_data_reg <= {(OUT_W - 3*LINK_W)'(0),
                             is_null(right_reg), link_id(right_reg),
                             is_null(left_reg), link_id(left_reg),
                             is_null(head_reg), link_id(head_reg)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `CHK_RST(a_no_write_idle, (state_reg == ST_IDLE) |-> !(wl_req.en || wr_req.en),
             "link memory written while idle")
    `CHK_RST(a_accept_exec, (s_tvalid && s_tready) |=> (state_reg == ST_EXEC),
             "accepted word did not start execution")
    `CHK_RST(a_wr2_insert, (state_reg == ST_WR2) |-> (kind_reg == KIND_INSERT && !tnone_reg),
             "second write pass outside a linked insert")
    `CHK_RST(a_fin_load,
             (state_reg == ST_FIN && (!m_tvalid || m_tready)) |=>
             (state_reg == ST_IDLE && m_tvalid),
             "result not presented after finish")
    `CHK_ALWAYS(a_reset_head, !rst_n |=> (head_reg == LINK_NULL || !rst_n || $past(rst_n)),
                "head pointer not null after reset")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for indexed_doubly_linked_list: directed list edits, then random
// well-formed edit runs mixed with corrupting noise, checked against an in-bench list model.
// Depends on idll_pkg for widths, link and id types, and the word kind codes.
module testbench
    import idll_pkg::*;
();

    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct {
        logic [1:0] kind;
        id_t        node_id;
        id_t        anchor_id;
        logic       target_none;
        logic       side;
    } edit_t;

    typedef struct {
        id_t  head_id;
        logic head_none;
        id_t  left_id;
        logic left_none;
        id_t  right_id;
        logic right_none;
    } view_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;   // node_id, anchor_id, target_none, side, zero pad
    logic [1:0]       s_tuser = '0;   // kind
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;        // head_id, head_none, left_id, left_none,
                                      // right_id, right_none, zero pad

    indexed_doubly_linked_list DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // list model
    link_t left_store [NODE_CNT];
    link_t right_store [NODE_CNT];
    link_t head_link = LINK_NULL;
    view_t pending_views [$];

    // stimulus bookkeeping
    id_t                 chain [$];
    logic [NODE_CNT-1:0] on_chain = '0;
    id_t                 known [$];
    logic [NODE_CNT-1:0] known_bits = '0;
    bit                  dirty = 1'b1;

    int gap_mode = 0;
    int ready_mode = 0;
    int hold_cnt = 0;
    int ready_roll;
    int mismatches = 0;
    int results_seen = 0;
    view_t got_view;
    view_t want_view;

    function automatic view_t apply_edit(edit_t w);
        link_t tl;
        link_t tr;
        link_t nl;
        link_t nr;
        link_t lk;
        view_t v;
        case (w.kind)
            KIND_INSERT:
                if (w.target_none) begin
                    left_store[w.node_id]  = LINK_NULL;
                    right_store[w.node_id] = LINK_NULL;
                    head_link = {1'b0, w.node_id};
                end else if (!w.side) begin
                    tl = left_store[w.anchor_id];
                    if (!tl[ID_W])
                        right_store[tl[ID_W-1:0]] = {1'b0, w.node_id};
                    else
                        head_link = {1'b0, w.node_id};
                    left_store[w.node_id]   = left_store[w.anchor_id];
                    right_store[w.node_id]  = {1'b0, w.anchor_id};
                    left_store[w.anchor_id] = {1'b0, w.node_id};
                end else begin
                    tr = right_store[w.anchor_id];
                    if (!tr[ID_W])
                        left_store[tr[ID_W-1:0]] = {1'b0, w.node_id};
                    right_store[w.node_id]   = right_store[w.anchor_id];
                    left_store[w.node_id]    = {1'b0, w.anchor_id};
                    right_store[w.anchor_id] = {1'b0, w.node_id};
                end
            KIND_REMOVE: begin
                nl = left_store[w.node_id];
                if (!nl[ID_W])
                    right_store[nl[ID_W-1:0]] = right_store[w.node_id];
                else
                    head_link = right_store[w.node_id];
                nr = right_store[w.node_id];
                if (!nr[ID_W])
                    left_store[nr[ID_W-1:0]] = left_store[w.node_id];
            end
            default: ;
        endcase
        v.head_none = head_link[ID_W];
        v.head_id   = head_link[ID_W] ? id_t'(0) : head_link[ID_W-1:0];
        lk = left_store[w.node_id];
        v.left_none = lk[ID_W];
        v.left_id   = lk[ID_W] ? id_t'(0) : lk[ID_W-1:0];
        lk = right_store[w.node_id];
        v.right_none = lk[ID_W];
        v.right_id   = lk[ID_W] ? id_t'(0) : lk[ID_W-1:0];
        return v;
    endfunction

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (gap_mode == 0 || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_edit(input edit_t w);
        int gap;
        s_tdata  <= {2'b00, w.side, w.target_none, w.anchor_id, w.node_id};
        s_tuser  <= w.kind;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_views.push_back(apply_edit(w));
        gap = idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [1:0] kind, input int node, input int target,
                         input logic tnone, input logic side);
        edit_t w;
        w.kind        = kind;
        w.node_id     = id_t'(node);
        w.anchor_id   = id_t'(target);
        w.target_none = tnone;
        w.side        = side;
        send_edit(w);
    endtask

    task automatic wait_drained();
        while (pending_views.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch on result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    function automatic id_t any_member();
        return chain[$urandom_range(0, chain.size() - 1)];
    endfunction

    function automatic id_t any_known();
        return known[$urandom_range(0, known.size() - 1)];
    endfunction

    function automatic id_t fresh_id();
        id_t n;
        n = id_t'($urandom_range(0, NODE_CNT - 1));
        while (on_chain[n])
            n = id_t'($urandom_range(0, NODE_CNT - 1));
        return n;
    endfunction

    function automatic void enlist(input id_t n);
        chain.push_back(n);
        on_chain[n] = 1'b1;
        if (!known_bits[n])
        begin
            known_bits[n] = 1'b1;
            known.push_back(n);
        end
    endfunction

    function automatic edit_t next_edit();
        edit_t w;
        int roll;
        int ins_pct;
        int idx;
        w.kind        = KIND_QUERY;
        w.node_id     = id_t'($urandom_range(0, NODE_CNT - 1));
        w.anchor_id   = id_t'($urandom_range(0, NODE_CNT - 1));
        w.target_none = 1'($urandom_range(0, 1));
        w.side        = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        // restart a fresh list after corruption, on an empty list, or now and then
        if (dirty || chain.size() == 0 || roll < 2)
        begin
            w.kind        = KIND_INSERT;
            w.target_none = 1'b1;
            chain.delete();
            on_chain = '0;
            dirty    = 1'b0;
            enlist(w.node_id);
            return w;
        end
        if (roll < 10)
        begin
            case ($urandom_range(0, 4))
                0: begin
                    w.kind    = KIND_SPARE;
                    w.node_id = any_member();
                end
                1: begin
                    w.kind    = $urandom_range(0, 1) ? KIND_QUERY : KIND_SPARE;
                    w.node_id = any_known();
                end
                2: begin
                    w.kind    = KIND_REMOVE;
                    w.node_id = any_known();
                    dirty     = 1'b1;
                end
                3: begin
                    w.kind        = KIND_INSERT;
                    w.target_none = 1'b0;
                    w.node_id     = any_member();
                    w.anchor_id   = ($urandom_range(0, 2) == 0) ? w.node_id : any_member();
                    dirty         = 1'b1;
                end
                default: begin
                    w.kind        = KIND_INSERT;
                    w.target_none = 1'b0;
                    w.node_id     = fresh_id();
                    w.anchor_id   = any_known();
                    dirty         = 1'b1;
                end
            endcase
            return w;
        end
        ins_pct = (chain.size() < 4) ? 80 : (chain.size() > 48) ? 25 : 50;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
        begin
            w.kind        = KIND_INSERT;
            w.target_none = 1'b0;
            w.node_id     = fresh_id();
            w.anchor_id   = any_member();
            enlist(w.node_id);
        end else if (roll < ins_pct + (100 - ins_pct) * 2 / 3)
        begin
            w.kind    = KIND_REMOVE;
            idx       = $urandom_range(0, chain.size() - 1);
            w.node_id = chain[idx];
            chain.delete(idx);
            on_chain[w.node_id] = 1'b0;
        end else begin
            w.node_id = ($urandom_range(0, 3) == 0) ? any_known() : any_member();
        end
        return w;
    endfunction

    task automatic run_edits(input int count);
        repeat (count) send_edit(next_edit());
    endtask

    task automatic test_directed();
        gap_mode   = 1;
        ready_mode = 1;
        issue(KIND_INSERT, 0, 0, 1'b1, 1'b0);
        issue(KIND_QUERY, 0, 1023, 1'b1, 1'b1);
        issue(KIND_INSERT, 1023, 0, 1'b0, 1'b1);
        issue(KIND_INSERT, 512, 0, 1'b0, 1'b0);
        issue(KIND_INSERT, 341, 512, 1'b0, 1'b1);
        issue(KIND_INSERT, 682, 1023, 1'b0, 1'b0);
        issue(KIND_SPARE, 341, 0, 1'b0, 1'b0);
        issue(KIND_QUERY, 512, 0, 1'b0, 1'b0);
        issue(KIND_QUERY, 0, 0, 1'b0, 1'b0);
        issue(KIND_QUERY, 682, 0, 1'b0, 1'b0);
        issue(KIND_QUERY, 1023, 0, 1'b0, 1'b0);
        issue(KIND_REMOVE, 512, 1023, 1'b1, 1'b1);
        issue(KIND_REMOVE, 1023, 0, 1'b0, 1'b0);
        issue(KIND_REMOVE, 0, 0, 1'b0, 1'b0);
        issue(KIND_QUERY, 0, 0, 1'b0, 1'b0);
        issue(KIND_QUERY, 1023, 0, 1'b0, 1'b0);
        issue(KIND_REMOVE, 0, 0, 1'b0, 1'b0);
        issue(KIND_INSERT, 341, 341, 1'b0, 1'b1);
        issue(KIND_INSERT, 1023, 1023, 1'b1, 1'b1);
        issue(KIND_INSERT, 5, 1023, 1'b0, 1'b0);
        issue(KIND_REMOVE, 1023, 0, 1'b0, 1'b0);
        issue(KIND_REMOVE, 5, 0, 1'b0, 1'b0);
        issue(KIND_QUERY, 5, 0, 1'b0, 1'b0);
        issue(KIND_INSERT, 341, 682, 1'b1, 1'b0);
        dirty = 1'b1;
    endtask

    task automatic test_mixed_traffic();
        gap_mode   = 1;
        ready_mode = 1;
        run_edits(450);
    endtask

    task automatic test_back_to_back();
        gap_mode   = 0;
        ready_mode = 0;
        run_edits(250);
    endtask

    task automatic test_pause_until_drained();
        gap_mode   = 1;
        ready_mode = 1;
        repeat (3)
        begin
            run_edits(40);
            s_tvalid <= 1'b0;
            wait_drained();
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic test_long_stalls();
        gap_mode   = 1;
        ready_mode = 2;
        run_edits(320);
    endtask

    always @(posedge clk)
    begin
        ready_roll = $urandom_range(0, 99);
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (ready_mode == 0)
            m_tready <= 1'b1;
        else if (ready_roll < ((ready_mode == 2) ? 50 : 70))
            m_tready <= 1'b1;
        else if (ready_roll < ((ready_mode == 2) ? 80 : 95))
        begin
            m_tready <= 1'b0;
            hold_cnt <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b0;
            hold_cnt <= $urandom_range(8, 40);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_views.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result word %h", m_tdata));
            end else begin
                want_view = pending_views.pop_front();
                got_view.head_id    = m_tdata[9:0];
                got_view.head_none  = m_tdata[10];
                got_view.left_id    = m_tdata[20:11];
                got_view.left_none  = m_tdata[21];
                got_view.right_id   = m_tdata[31:22];
                got_view.right_none = m_tdata[32];
                check_field("head_id", 32'(got_view.head_id), 32'(want_view.head_id));
                check_field("head_none", 32'(got_view.head_none), 32'(want_view.head_none));
                check_field("left_id", 32'(got_view.left_id), 32'(want_view.left_id));
                check_field("left_none", 32'(got_view.left_none), 32'(want_view.left_none));
                check_field("right_id", 32'(got_view.right_id), 32'(want_view.right_id));
                check_field("right_none", 32'(got_view.right_none),
                            32'(want_view.right_none));
            end
            results_seen++;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_mixed_traffic();
        test_back_to_back();
        test_pause_until_drained();
        test_long_stalls();
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending_views.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
